// File: design/hbd_pkg.sv
// hbd_pkg: shared types, constants and helpers for the half-space buoyancy
// and drag force pipeline. No dependencies; compiled first.
`default_nettype none

package hbd_pkg;

  localparam int FW  = 48;  // field width of Q16.32 words
  localparam int GW  = 32;  // group mask width
  localparam int CIW = 4;   // config index width

  typedef logic signed [63:0] w64_t;

  // Largest magnitude a fixed-point product keeps (2^62 - 1)
  localparam logic [61:0] QMAX = '1;

  localparam w64_t PI_THIRD_Q32       = 64'sd4497679235;
  localparam w64_t THREE_QUARTERS_Q32 = 64'sd3221225472;
  localparam w64_t LIM48_POS          = 64'sd140737488355327;
  localparam w64_t LIM48_NEG          = -64'sd140737488355328;

  typedef enum logic [CIW-1:0] {
    REG_GRAVITY_X, REG_GRAVITY_Y, REG_GRAVITY_Z, REG_SURFACE_OFFSET,
    REG_LIQUID_DENSITY, REG_DRAG_COEFFICIENT, REG_GROUP_MASK, REG_DRAG_ENABLE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_UNTOUCHED, ST_PARTIAL, ST_FULL, ST_ZERO_G
  } status_t;

  function automatic w64_t sx64(input logic [FW-1:0] v);
    return {{(64-FW){v[FW-1]}}, v};
  endfunction

  function automatic w64_t zx64(input logic [FW-1:0] v);
    return {{(64-FW){1'b0}}, v};
  endfunction

  function automatic logic signed [FW-1:0] sat48(input w64_t v);
    if (v > LIM48_POS) begin
      return LIM48_POS[FW-1:0];
    end else if (v < LIM48_NEG) begin
      return LIM48_NEG[FW-1:0];
    end
    return v[FW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/hbd_in_if.sv
// hbd_in_if: particle word channel (valid/ready plus particle fields).
// Depends on hbd_pkg.
`default_nettype none

interface hbd_in_if;
  import hbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [GW-1:0]        particle_group;
  logic [FW-1:0]        radius;
  logic [FW-1:0]        body_volume;
  logic signed [FW-1:0] pos_x, pos_y, pos_z;
  logic signed [FW-1:0] vel_x, vel_y, vel_z;
  logic signed [FW-1:0] spin_x, spin_y, spin_z;

  modport source (output valid, particle_group, radius, body_volume, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, input ready);
  modport sink   (input valid, particle_group, radius, body_volume, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, output ready);
endinterface

`default_nettype wire

// File: design/hbd_out_if.sv
// hbd_out_if: result word channel (valid/ready, force, torque, status).
// Depends on hbd_pkg.
`default_nettype none

interface hbd_out_if;
  import hbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] force_x, force_y, force_z;
  logic signed [FW-1:0] torque_x, torque_y, torque_z;
  logic [1:0]           status;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  status, input ready);
  modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  status, output ready);
endinterface

`default_nettype wire

// File: design/hbd_cfg_if.sv
// hbd_cfg_if: register write channel (valid/ready, index, data).
// Depends on hbd_pkg.
`default_nettype none

interface hbd_cfg_if;
  import hbd_pkg::*;
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [FW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/hbd_delay.sv
// hbd_delay: stall-aware shift line that keeps side values in step with the pipe.
// No dependencies.
`default_nettype none

module hbd_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);
  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[D-1];
endmodule

`default_nettype wire

// File: design/hbd_mul.sv
// hbd_mul: two-stage signed 64x64 multiplier; four 32x32 partials, then sum.
// Gives the exact magnitude product and the saturated Q32.32 product. Uses hbd_pkg.
`default_nettype none

module hbd_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire hbd_pkg::w64_t      a_i,
  input  wire hbd_pkg::w64_t      b_i,
  output logic [127:0]            prod_o,
  output logic                    neg_o,
  output hbd_pkg::w64_t           q_o
);
  import hbd_pkg::*;

  logic [63:0]  am, bm;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg1_r;
  logic [127:0] sum;
  logic [63:0]  mag_q;
  logic [127:0] prod_r;
  logic         neg_r;
  w64_t         q_r;

  assign am = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign bm = b_i[63] ? 64'(-b_i) : 64'(b_i);

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= {32'd0, am[31:0]}  * {32'd0, bm[31:0]};
      p01_r  <= {32'd0, am[31:0]}  * {32'd0, bm[63:32]};
      p10_r  <= {32'd0, am[63:32]} * {32'd0, bm[31:0]};
      p11_r  <= {32'd0, am[63:32]} * {32'd0, bm[63:32]};
      neg1_r <= a_i[63] ^ b_i[63];
    end
  end

  assign sum = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
             + {p11_r, 64'd0};
  // saturate at 2^62-1 before the sign goes back on
  assign mag_q = (sum[127:94] != '0) ? {2'b00, QMAX} : {2'b00, sum[93:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sum;
      neg_r  <= neg1_r;
      q_r    <= neg1_r ? -$signed(mag_q) : $signed(mag_q);
    end
  end

  assign prod_o = prod_r;
  assign neg_o  = neg_r;
  assign q_o    = q_r;
endmodule

`default_nettype wire

// File: design/hbd_isqrt.sv
// hbd_isqrt: pipelined floor square root, one result bit per stage.
// No dependencies.
`default_nettype none

module hbd_isqrt #(
  parameter int IW = 96
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [IW-1:0]   x_i,
  output logic      [IW/2-1:0] root_o
);
  localparam int OW = IW / 2;
  localparam int RW = OW + 1;

  logic [IW-1:0] rad_r  [OW];
  logic [RW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];

  for (genvar k = 0; k < OW; k++) begin : g_st
    logic [IW-1:0] rad_in;
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [RW+1:0] remx, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_in  = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign remx  = {rem_in, rad_in[IW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[IW-3:0], 2'b00};
        rem_r[k]  <= ge ? RW'(remx - trial) : remx[RW-1:0];
        root_r[k] <= {root_in[OW-2:0], ge};
      end
    end
  end

  assign root_o = root_r[OW-1];
endmodule

`default_nettype wire

// File: design/hbd_div.sv
// hbd_div: pipelined restoring divider, one quotient bit per stage; flags a
// quotient that needs more than QW bits. No dependencies.
`default_nettype none

module hbd_div #(
  parameter int NW = 96,
  parameter int DW = 48,
  parameter int QW = 62
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] q_o,
  output logic               sat_o
);
  localparam int HW = NW - QW;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];
  logic          sat_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] low_in, q_in;
    logic          sat_in;
    logic [DW:0]   remx;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign q_in   = '0;
      assign den_in = den_i;
      assign sat_in = {{(DW-HW){1'b0}}, num_i[NW-1:QW]} >= den_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign sat_in = sat_r[k-1];
    end

    assign remx = {rem_in, low_in[QW-1]};
    assign ge   = remx >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(remx - {1'b0, den_in}) : remx[DW-1:0];
        low_r[k] <= {low_in[QW-2:0], 1'b0};
        q_r[k]   <= {q_in[QW-2:0], ge};
        den_r[k] <= den_in;
        sat_r[k] <= sat_in;
      end
    end
  end

  assign q_o   = q_r[QW-1];
  assign sat_o = sat_r[QW-1];
endmodule

`default_nettype wire

// File: design/halfspace_buoyancy_drag_force_top.sv
// Top level of the half-space buoyancy and quadratic drag force pipeline.
// Uses hbd_pkg, hbd_in_if, hbd_out_if, hbd_cfg_if, hbd_mul, hbd_isqrt,
// hbd_div and hbd_delay.
//
// Usage:
//  - cfg_ch writes one register per word (index = register number, always
//    ready). Write only while the pipe is empty; items in flight read the
//    registers live.
//  - in_ch takes one particle word per cycle unless stalled; out_ch gives exactly
//    one result word (force, torque, status) per particle, in order.
//  - Throughput: one word per cycle unless stalled. The pipeline depth is set
//    by the 48-step square root of |g| followed by the 62-step divider for the
//    height, then the spherical-cap product chain.
//  - Stall: the whole pipe advances only when the output register is empty or
//    being taken, so in_ch.ready follows out_ch.ready; a stalled result holds
//    and nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) clears all valid bits and the registers
//    to zero, so |g| = 0 and every result reads status zero-gravity.
//  - Drag (force and torque) is computed in parallel with the height path
//    and retimed to meet it at the final add and saturate stage.
`default_nettype none

module halfspace_buoyancy_drag_force_top (
  input  wire logic clk,
  input  wire logic rst_n,
  hbd_in_if.sink    in_ch,
  hbd_out_if.source out_ch,
  hbd_cfg_if.sink   cfg_ch
);
  import hbd_pkg::*;

  // stage numbers (registers holding the value)
  localparam int SQ_LAT = 48;
  localparam int QW     = 62;
  localparam int T_SUM  = 3;
  localparam int T_M    = 4;
  localparam int T_NORM = T_SUM + SQ_LAT;
  localparam int T_DIV  = T_NORM + QW;
  localparam int T_H    = T_DIV + 1;
  localparam int T_DP   = T_H + 1;
  localparam int T_C1   = T_DP + 2;
  localparam int T_C2   = T_C1 + 2;
  localparam int T_C3   = T_C2 + 2;
  localparam int T_RV   = T_C3 + 2;
  localparam int T_FB   = T_RV + 2;
  localparam int T_OUT  = T_FB + 1;
  localparam int T_K    = 6;
  localparam int T_R5   = 6;
  localparam int T_M1   = 8;
  localparam int T_KV   = T_NORM + 2;
  localparam int T_FD   = T_KV + 2;

  // ---------------- control ----------------
  logic           en;
  logic [T_OUT:0] vld_r;

  assign en          = !vld_r[T_OUT] || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_OUT-1:0], in_ch.valid};
    end
  end

  // ---------------- registers ----------------
  logic signed [FW-1:0] gx_r, gy_r, gz_r, surf_r;
  logic [FW-1:0]        rho_r, cd_r;
  logic [GW-1:0]        gmask_r;
  logic                 de_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r    <= '0;
      gy_r    <= '0;
      gz_r    <= '0;
      surf_r  <= '0;
      rho_r   <= '0;
      cd_r    <= '0;
      gmask_r <= '0;
      de_r    <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_GRAVITY_X:        gx_r    <= cfg_ch.data;
        REG_GRAVITY_Y:        gy_r    <= cfg_ch.data;
        REG_GRAVITY_Z:        gz_r    <= cfg_ch.data;
        REG_SURFACE_OFFSET:   surf_r  <= cfg_ch.data;
        REG_LIQUID_DENSITY:   rho_r   <= cfg_ch.data;
        REG_DRAG_COEFFICIENT: cd_r    <= cfg_ch.data;
        REG_GROUP_MASK:       gmask_r <= cfg_ch.data[GW-1:0];
        REG_DRAG_ENABLE:      de_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: input capture ----------------
  logic [GW-1:0]        grp0_r;
  logic [FW-1:0]        rad0_r, vol0_r;
  logic signed [FW-1:0] p0_r [3];
  logic signed [FW-1:0] v0_r [3];
  logic signed [FW-1:0] w0_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      grp0_r  <= in_ch.particle_group;
      rad0_r  <= in_ch.radius;
      vol0_r  <= in_ch.body_volume;
      p0_r[0] <= in_ch.pos_x;
      p0_r[1] <= in_ch.pos_y;
      p0_r[2] <= in_ch.pos_z;
      v0_r[0] <= in_ch.vel_x;
      v0_r[1] <= in_ch.vel_y;
      v0_r[2] <= in_ch.vel_z;
      w0_r[0] <= in_ch.spin_x;
      w0_r[1] <= in_ch.spin_y;
      w0_r[2] <= in_ch.spin_z;
    end
  end

  w64_t g64 [3];
  w64_t p64 [3];
  w64_t v64 [3];
  w64_t w64 [3];
  logic hit;

  always_comb begin
    g64[0] = sx64(gx_r);
    g64[1] = sx64(gy_r);
    g64[2] = sx64(gz_r);
    for (int i = 0; i < 3; i++) begin
      p64[i] = sx64(p0_r[i]);
      v64[i] = sx64(v0_r[i]);
      w64[i] = sx64(w0_r[i]);
    end
  end

  // mask of zero selects every particle
  assign hit = (gmask_r == '0) || ((gmask_r & grp0_r) != '0);

  // ---------------- squares and dot product ----------------
  logic [127:0] gsq [3];
  logic [127:0] vsq [3];
  logic [127:0] wsq [3];
  logic [127:0] dotp [3];
  logic         dotn [3];

  for (genvar i = 0; i < 3; i++) begin : g_vec0
    hbd_mul u_gsq (.clk(clk), .en(en), .a_i(g64[i]), .b_i(g64[i]),
                   .prod_o(gsq[i]), .neg_o(), .q_o());
    hbd_mul u_vsq (.clk(clk), .en(en), .a_i(v64[i]), .b_i(v64[i]),
                   .prod_o(vsq[i]), .neg_o(), .q_o());
    hbd_mul u_wsq (.clk(clk), .en(en), .a_i(w64[i]), .b_i(w64[i]),
                   .prod_o(wsq[i]), .neg_o(), .q_o());
    hbd_mul u_dot (.clk(clk), .en(en), .a_i(p64[i]), .b_i(g64[i]),
                   .prod_o(dotp[i]), .neg_o(dotn[i]), .q_o());
  end

  logic [95:0] gsum_r, vsum_r, wsum_r, pos_r, neg_r;
  logic [95:0] pos_s, neg_s;

  always_comb begin
    pos_s = '0;
    neg_s = '0;
    for (int i = 0; i < 3; i++) begin
      if (dotn[i]) neg_s = neg_s + dotp[i][95:0];
      else         pos_s = pos_s + dotp[i][95:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gsum_r <= gsq[0][95:0] + gsq[1][95:0] + gsq[2][95:0];
      vsum_r <= vsq[0][95:0] + vsq[1][95:0] + vsq[2][95:0];
      wsum_r <= wsq[0][95:0] + wsq[1][95:0] + wsq[2][95:0];
      pos_r  <= pos_s;
      neg_r  <= neg_s;
    end
  end

  // signed dot product as sign and magnitude
  logic [95:0] m_r;
  logic        mneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mneg_r <= neg_r > pos_r;
      m_r    <= (neg_r > pos_r) ? neg_r - pos_r : pos_r - neg_r;
    end
  end

  // ---------------- norms ----------------
  logic [FW-1:0] gnorm, vnorm, wnorm;

  hbd_isqrt #(.IW(96)) u_gnorm (.clk(clk), .en(en), .x_i(gsum_r), .root_o(gnorm));
  hbd_isqrt #(.IW(96)) u_vnorm (.clk(clk), .en(en), .x_i(vsum_r), .root_o(vnorm));
  hbd_isqrt #(.IW(96)) u_wnorm (.clk(clk), .en(en), .x_i(wsum_r), .root_o(wnorm));

  // ---------------- height: surface offset - pos.g / |g| ----------------
  logic [96:0]   mdly;
  logic [QW-1:0] dq;
  logic          dsat, qneg, zero_dp;

  hbd_delay #(.W(97), .D(T_NORM - T_M)) u_dly_m (
    .clk(clk), .en(en), .d_i({mneg_r, m_r}), .q_o(mdly));

  hbd_div #(.NW(96), .DW(FW), .QW(QW)) u_div (
    .clk(clk), .en(en), .num_i(mdly[95:0]), .den_i(gnorm), .q_o(dq), .sat_o(dsat));

  hbd_delay #(.W(1), .D(QW)) u_dly_qneg (
    .clk(clk), .en(en), .d_i(mdly[96]), .q_o(qneg));

  hbd_delay #(.W(1), .D(T_DP - T_NORM)) u_dly_zero (
    .clk(clk), .en(en), .d_i(gnorm == '0), .q_o(zero_dp));

  w64_t qmag, qs, h_r;

  assign qmag = dsat ? {2'b00, QMAX} : {2'b00, dq};
  assign qs   = qneg ? -qmag : qmag;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= sx64(surf_r) - qs;
    end
  end

  // ---------------- depth and case ----------------
  logic [FW-1:0] rad_h, raddp_r;
  w64_t          radh64, dp_s, dp_r;
  logic          below_r, partial_r, hit_dp;

  hbd_delay #(.W(FW), .D(T_H)) u_dly_rad (
    .clk(clk), .en(en), .d_i(rad0_r), .q_o(rad_h));
  hbd_delay #(.W(1), .D(T_DP)) u_dly_hit (
    .clk(clk), .en(en), .d_i(hit), .q_o(hit_dp));

  assign radh64 = zx64(rad_h);
  assign dp_s   = radh64 - h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r      <= dp_s;
      below_r   <= h_r < radh64;
      partial_r <= dp_s < (radh64 <<< 1);
      raddp_r   <= rad_h;
    end
  end

  status_t    status_dp;
  logic [1:0] st_c3, st_fb;
  w64_t       tr, tr_c1;

  always_comb begin
    if (zero_dp)                 status_dp = ST_ZERO_G;
    else if (!hit_dp || !below_r) status_dp = ST_UNTOUCHED;
    else if (partial_r)          status_dp = ST_PARTIAL;
    else                         status_dp = ST_FULL;
  end

  assign tr = (zx64(raddp_r) <<< 1) + zx64(raddp_r) - dp_r;

  hbd_delay #(.W(2), .D(T_C3 - T_DP)) u_dly_st0 (
    .clk(clk), .en(en), .d_i(status_dp), .q_o(st_c3));
  hbd_delay #(.W(2), .D(T_FB - T_C3)) u_dly_st1 (
    .clk(clk), .en(en), .d_i(st_c3), .q_o(st_fb));
  hbd_delay #(.W(64), .D(T_C1 - T_DP)) u_dly_tr (
    .clk(clk), .en(en), .d_i(tr), .q_o(tr_c1));

  // ---------------- cap volume and buoyancy ----------------
  w64_t          c1, c2, c3, vs, rv;
  logic [FW-1:0] vol_c3;
  w64_t          fb [3];

  hbd_delay #(.W(FW), .D(T_C3)) u_dly_vol (
    .clk(clk), .en(en), .d_i(vol0_r), .q_o(vol_c3));

  hbd_mul u_c1 (.clk(clk), .en(en), .a_i(dp_r), .b_i(dp_r),
                .prod_o(), .neg_o(), .q_o(c1));
  hbd_mul u_c2 (.clk(clk), .en(en), .a_i(c1), .b_i(w64_t'(tr_c1)),
                .prod_o(), .neg_o(), .q_o(c2));
  hbd_mul u_c3 (.clk(clk), .en(en), .a_i(c2), .b_i(PI_THIRD_Q32),
                .prod_o(), .neg_o(), .q_o(c3));

  assign vs = (st_c3 == ST_PARTIAL) ? c3 : zx64(vol_c3);

  hbd_mul u_rv (.clk(clk), .en(en), .a_i(zx64(rho_r)), .b_i(vs),
                .prod_o(), .neg_o(), .q_o(rv));

  for (genvar i = 0; i < 3; i++) begin : g_fb
    hbd_mul u_fb (.clk(clk), .en(en), .a_i(rv), .b_i(g64[i]),
                  .prod_o(), .neg_o(), .q_o(fb[i]));
  end

  // ---------------- drag force ----------------
  w64_t k1, k2, kq, kd, kv;
  logic [3*FW-1:0] vd, wd;
  w64_t fd [3];
  logic [191:0] fd_pk, fd_fb;

  hbd_mul u_k1 (.clk(clk), .en(en), .a_i(zx64(cd_r)), .b_i(zx64(rad0_r)),
                .prod_o(), .neg_o(), .q_o(k1));
  hbd_mul u_k2 (.clk(clk), .en(en), .a_i(zx64(rho_r)), .b_i(k1 >>> 1),
                .prod_o(), .neg_o(), .q_o(k2));
  hbd_mul u_k3 (.clk(clk), .en(en), .a_i(k2), .b_i(THREE_QUARTERS_Q32),
                .prod_o(), .neg_o(), .q_o(kq));

  hbd_delay #(.W(64), .D(T_NORM - T_K)) u_dly_k (
    .clk(clk), .en(en), .d_i(kq), .q_o(kd));

  hbd_mul u_kv (.clk(clk), .en(en), .a_i(w64_t'(kd)), .b_i(zx64(vnorm)),
                .prod_o(), .neg_o(), .q_o(kv));

  hbd_delay #(.W(3*FW), .D(T_KV)) u_dly_v (
    .clk(clk), .en(en), .d_i({v0_r[2], v0_r[1], v0_r[0]}), .q_o(vd));
  hbd_delay #(.W(3*FW), .D(T_KV)) u_dly_w (
    .clk(clk), .en(en), .d_i({w0_r[2], w0_r[1], w0_r[0]}), .q_o(wd));

  // ---------------- drag torque ----------------
  w64_t r2, r4, r5, cr, cr_d, m1, m1_d, mm;
  logic [FW-1:0] rad_r5;
  w64_t tq [3];
  logic [191:0] tq_pk, tq_fb;

  hbd_mul u_r2 (.clk(clk), .en(en), .a_i(zx64(rad0_r)), .b_i(zx64(rad0_r)),
                .prod_o(), .neg_o(), .q_o(r2));
  hbd_mul u_r4 (.clk(clk), .en(en), .a_i(r2), .b_i(r2),
                .prod_o(), .neg_o(), .q_o(r4));
  hbd_delay #(.W(FW), .D(T_R5 - 2)) u_dly_rr (
    .clk(clk), .en(en), .d_i(rad0_r), .q_o(rad_r5));
  hbd_mul u_r5 (.clk(clk), .en(en), .a_i(r4), .b_i(zx64(rad_r5)),
                .prod_o(), .neg_o(), .q_o(r5));

  hbd_mul u_cr (.clk(clk), .en(en), .a_i(zx64(cd_r)), .b_i(zx64(rho_r >> 1)),
                .prod_o(), .neg_o(), .q_o(cr));
  hbd_delay #(.W(64), .D(T_R5 - 2)) u_dly_cr (
    .clk(clk), .en(en), .d_i(cr), .q_o(cr_d));
  hbd_mul u_m1 (.clk(clk), .en(en), .a_i(w64_t'(cr_d)), .b_i(r5),
                .prod_o(), .neg_o(), .q_o(m1));
  hbd_delay #(.W(64), .D(T_NORM - T_M1)) u_dly_m1 (
    .clk(clk), .en(en), .d_i(m1), .q_o(m1_d));
  hbd_mul u_mm (.clk(clk), .en(en), .a_i(w64_t'(m1_d)), .b_i(zx64(wnorm)),
                .prod_o(), .neg_o(), .q_o(mm));

  for (genvar i = 0; i < 3; i++) begin : g_drag
    hbd_mul u_fd (.clk(clk), .en(en), .a_i(kv), .b_i(sx64(vd[i*FW +: FW])),
                  .prod_o(), .neg_o(), .q_o(fd[i]));
    hbd_mul u_tq (.clk(clk), .en(en), .a_i(mm), .b_i(sx64(wd[i*FW +: FW])),
                  .prod_o(), .neg_o(), .q_o(tq[i]));
    assign fd_pk[i*64 +: 64] = fd[i];
    assign tq_pk[i*64 +: 64] = tq[i];
  end

  hbd_delay #(.W(192), .D(T_FB - T_FD)) u_dly_fd (
    .clk(clk), .en(en), .d_i(fd_pk), .q_o(fd_fb));
  hbd_delay #(.W(192), .D(T_FB - T_FD)) u_dly_tq (
    .clk(clk), .en(en), .d_i(tq_pk), .q_o(tq_fb));

  // ---------------- combine, saturate, output register ----------------
  logic                 apply, drag_on;
  w64_t                 fsum [3];
  logic signed [FW-1:0] force_r [3];
  logic signed [FW-1:0] torque_r [3];
  logic [1:0]           status_r;

  assign apply   = (st_fb == ST_PARTIAL) || (st_fb == ST_FULL);
  assign drag_on = apply && de_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = -fb[i] - (drag_on ? w64_t'(fd_fb[i*64 +: 64]) : 64'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        force_r[i]  <= apply ? sat48(fsum[i]) : '0;
        torque_r[i] <= drag_on ? sat48(-w64_t'(tq_fb[i*64 +: 64])) : '0;
      end
      status_r <= st_fb;
    end
  end

  assign out_ch.valid    = vld_r[T_OUT];
  assign out_ch.force_x  = force_r[0];
  assign out_ch.force_y  = force_r[1];
  assign out_ch.force_z  = force_r[2];
  assign out_ch.torque_x = torque_r[0];
  assign out_ch.torque_y = torque_r[1];
  assign out_ch.torque_z = torque_r[2];
  assign out_ch.status   = status_r;
endmodule

`default_nettype wire

// File: design/hbd_checker.sv
// hbd_checker: port-level assertions on result words, bound to the top level.
// Uses hbd_pkg.
`default_nettype none

module hbd_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic signed [47:0]   force_x,
  input wire logic signed [47:0]   force_y,
  input wire logic signed [47:0]   force_z,
  input wire logic signed [47:0]   torque_x,
  input wire logic signed [47:0]   torque_y,
  input wire logic signed [47:0]   torque_z,
  input wire logic [1:0]           status
);
  import hbd_pkg::*;

  logic force_zero, torque_zero;

  assign force_zero  = (force_x == '0) && (force_y == '0) && (force_z == '0);
  assign torque_zero = (torque_x == '0) && (torque_y == '0) && (torque_z == '0);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word visible right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(force_x))
    else $error("stalled result word changed");

  a_zero_g: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_ZERO_G |-> force_zero && torque_zero)
    else $error("zero gravity word carries force or torque");

  a_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_UNTOUCHED |-> force_zero && torque_zero)
    else $error("untouched particle got force or torque");

  a_torque_case: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !torque_zero |-> status == ST_PARTIAL || status == ST_FULL)
    else $error("torque on a particle that is not submerged");
endmodule

bind halfspace_buoyancy_drag_force_top hbd_checker u_hbd_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .force_x(out_ch.force_x), .force_y(out_ch.force_y), .force_z(out_ch.force_z),
  .torque_x(out_ch.torque_x), .torque_y(out_ch.torque_y), .torque_z(out_ch.torque_z),
  .status(out_ch.status)
);

`default_nettype wire
